FILE: rtl/rbsi_pkg.sv
// Shared widths, constants and payload types of the ray/box slab intersection pipeline.
package rbsi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CW        = 32;                 // coordinate width
  localparam int DW        = CW + 1;             // bound minus origin
  localparam int SQ_W      = 2 * CW;             // sum of squared heading components
  localparam int LEN_W     = CW;                 // floor of the heading length
  localparam int UQ_W      = FRAC_BITS + 1;      // unit component magnitude
  localparam int UN_W      = CW + FRAC_BITS;     // unit numerator
  localparam int SN_W      = DW + FRAC_BITS;     // slab numerator
  localparam int TQ_W      = CW;                 // slab quotient bits worked out
  localparam int SH_W      = SN_W - TQ_W;        // numerator head, checked for overflow

  localparam logic signed [CW-1:0] T_NEG_INF = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] T_POS_INF = {1'b0, {(CW-1){1'b1}}};

  typedef struct packed {
    logic [2:0][DW-1:0] dlo;   // box_min - origin per axis
    logic [2:0][DW-1:0] dhi;   // box_max - origin per axis
  } box_t;

  typedef struct packed {
    logic [2:0][CW-1:0] mag;
    logic [2:0]         neg;
  } head_t;

  typedef struct packed {
    logic [2:0] uzero;         // unit component rounded to zero
    logic [2:0] zmiss;         // origin outside the slab of that axis
  } slab_flag_t;

endpackage

FILE: rtl/ray_box_slab_intersect.sv
// Ray versus axis-aligned box slab test, fully pipelined, top level.
// Takes one request per clock while the output is taken and returns one result per request,
// in order, through 90 register stages (input stage, squares, sum, 32 square-root stages,
// 18 unit-scaling stages, 34 slab-division stages, two combining stages and the output
// register). The depth is set by the bit-per-stage square root and dividers. When the
// output is not taken the whole pipeline holds, so nothing is dropped.
module ray_box_slab_intersect (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
  // origin_x, origin_y, origin_z, heading_x, heading_y, heading_z (32 bits each)
  input  logic [383:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // hit [0], hit_distance [31:1]
  output logic [31:0]  m_axis_tdata_o
);

  localparam int CW   = rbsi_pkg::CW;
  localparam int DW   = rbsi_pkg::DW;
  localparam int UQ_W = rbsi_pkg::UQ_W;

  logic en;

  logic signed [2:0][CW-1:0] bmin, bmax, org, hd;

  logic            in_vld_q;
  rbsi_pkg::box_t  in_bx_q;
  rbsi_pkg::head_t in_hd_q;

  logic                       sq_vld;
  logic [rbsi_pkg::LEN_W-1:0] sq_len;
  rbsi_pkg::head_t            sq_hd;
  rbsi_pkg::box_t             sq_bx;

  logic                       nm_vld;
  logic [2:0][UQ_W-1:0]       nm_umag;
  logic [2:0]                 nm_uneg;
  rbsi_pkg::box_t             nm_bx;

  logic                       sl_vld;
  logic signed [5:0][CW-1:0]  sl_t;
  rbsi_pkg::slab_flag_t       sl_fl;

  logic signed [2:0][CW-1:0]  ord_s, ord_e;
  logic [2:0]                 ord_miss;

  logic                       a_vld_q;
  logic signed [2:0][CW-1:0]  a_s_q, a_e_q;
  logic                       a_miss_q;

  logic                       b_vld_q;
  logic signed [CW-1:0]       b_smax_q, b_emin_q;
  logic                       b_miss_q;
  logic signed [CW-1:0]       smax01, emin01;

  logic                       out_vld_q;
  logic                       out_hit_q;
  logic [CW-2:0]              out_dist_q;

  assign en              = ~out_vld_q | m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      bmin[a] = s_axis_tdata_i[CW*a +: CW];
      bmax[a] = s_axis_tdata_i[CW*(3+a) +: CW];
      org[a]  = s_axis_tdata_i[CW*(6+a) +: CW];
      hd[a]   = s_axis_tdata_i[CW*(9+a) +: CW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q  <= s_axis_tvalid_i;
      a_vld_q   <= sl_vld;
      b_vld_q   <= a_vld_q;
      out_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        in_bx_q.dlo[a]  <= DW'($signed(bmin[a])) - DW'($signed(org[a]));
        in_bx_q.dhi[a]  <= DW'($signed(bmax[a])) - DW'($signed(org[a]));
        in_hd_q.mag[a]  <= hd[a][CW-1] ? CW'(-hd[a]) : CW'(hd[a]);
        in_hd_q.neg[a]  <= hd[a][CW-1];
      end
    end
  end

  rbsi_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_vld_q),
    .head_i  (in_hd_q),
    .box_i   (in_bx_q),
    .valid_o (sq_vld),
    .len_o   (sq_len),
    .head_o  (sq_hd),
    .box_o   (sq_bx)
  );

  rbsi_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_vld),
    .len_i   (sq_len),
    .head_i  (sq_hd),
    .box_i   (sq_bx),
    .valid_o (nm_vld),
    .umag_o  (nm_umag),
    .uneg_o  (nm_uneg),
    .box_o   (nm_bx)
  );

  rbsi_slab u_slab (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (nm_vld),
    .umag_i  (nm_umag),
    .uneg_i  (nm_uneg),
    .box_i   (nm_bx),
    .valid_o (sl_vld),
    .t_o     (sl_t),
    .flag_o  (sl_fl)
  );

  // Order entry and exit per axis; a flat axis is unbounded unless the origin is outside
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (sl_fl.uzero[a]) begin
        ord_s[a]    = rbsi_pkg::T_NEG_INF;
        ord_e[a]    = rbsi_pkg::T_POS_INF;
        ord_miss[a] = sl_fl.zmiss[a];
      end else begin
        ord_s[a]    = ($signed(sl_t[a]) > $signed(sl_t[a+3])) ? sl_t[a+3] : sl_t[a];
        ord_e[a]    = ($signed(sl_t[a]) > $signed(sl_t[a+3])) ? sl_t[a] : sl_t[a+3];
        ord_miss[a] = ord_e[a][CW-1];
      end
    end
  end

  always_comb begin
    smax01 = ($signed(a_s_q[1]) > $signed(a_s_q[0])) ? a_s_q[1] : a_s_q[0];
    emin01 = ($signed(a_e_q[1]) < $signed(a_e_q[0])) ? a_e_q[1] : a_e_q[0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_s_q      <= ord_s;
      a_e_q      <= ord_e;
      a_miss_q   <= |ord_miss;
      b_smax_q   <= ($signed(a_s_q[2]) > smax01) ? a_s_q[2] : smax01;
      b_emin_q   <= ($signed(a_e_q[2]) < emin01) ? a_e_q[2] : emin01;
      b_miss_q   <= a_miss_q;
      out_hit_q  <= ~b_miss_q & (b_smax_q < b_emin_q);
      out_dist_q <= (~b_miss_q & (b_smax_q < b_emin_q) & (b_smax_q > 0))
                    ? b_smax_q[CW-2:0] : '0;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {out_dist_q, out_hit_q};

  a_miss_zero_dist : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[0]) |-> (m_axis_tdata_o[31:1] == '0))
    else $error("distance not zero on a miss");

  a_unit_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    nm_vld |-> ((nm_umag[0] <= UQ_W'(1 << rbsi_pkg::FRAC_BITS)) &&
                (nm_umag[1] <= UQ_W'(1 << rbsi_pkg::FRAC_BITS)) &&
                (nm_umag[2] <= UQ_W'(1 << rbsi_pkg::FRAC_BITS))))
    else $error("unit heading component above one");

  a_slab_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_vld_q |-> (($signed(a_s_q[0]) <= $signed(a_e_q[0])) &&
                 ($signed(a_s_q[1]) <= $signed(a_e_q[1])) &&
                 ($signed(a_s_q[2]) <= $signed(a_e_q[2]))))
    else $error("slab entry after exit");

endmodule

FILE: rtl/rbsi_sqrt.sv
// Squares, sums and takes the integer square root of the heading, one root bit per stage.
module rbsi_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  rbsi_pkg::head_t               head_i,
  input  rbsi_pkg::box_t                box_i,
  output logic                          valid_o,
  output logic [rbsi_pkg::LEN_W-1:0]    len_o,
  output rbsi_pkg::head_t               head_o,
  output rbsi_pkg::box_t                box_o
);

  localparam int SQ_W  = rbsi_pkg::SQ_W;
  localparam int LEN_W = rbsi_pkg::LEN_W;
  localparam int RW    = LEN_W + 3;

  logic [2:0][SQ_W-1:0] sq_q;
  logic                 sq_vld_q;
  rbsi_pkg::head_t      sq_hd_q;
  rbsi_pkg::box_t       sq_bx_q;

  logic [SQ_W-1:0]      rad_q  [LEN_W+1];
  logic [RW-1:0]        rem_q  [LEN_W+1];
  logic [LEN_W-1:0]     root_q [LEN_W+1];
  logic                 vld_q  [LEN_W+1];
  rbsi_pkg::head_t      hd_q   [LEN_W+1];
  rbsi_pkg::box_t       bx_q   [LEN_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= 1'b0;
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      sq_vld_q <= valid_i;
      vld_q[0] <= sq_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int a = 0; a < 3; a++) begin
        sq_q[a] <= SQ_W'(head_i.mag[a]) * SQ_W'(head_i.mag[a]);
      end
      sq_hd_q   <= head_i;
      sq_bx_q   <= box_i;
      rad_q[0]  <= sq_q[0] + sq_q[1] + sq_q[2];
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      hd_q[0]   <= sq_hd_q;
      bx_q[0]   <= sq_bx_q;
    end
  end

  for (genvar k = 1; k <= LEN_W; k++) begin : g_root
    logic [RW-1:0] cur;
    logic [RW-1:0] trial;
    logic          ge;

    always_comb begin
      cur   = {rem_q[k-1][RW-3:0], rad_q[k-1][SQ_W-1 -: 2]};
      trial = RW'({root_q[k-1], 2'b01});
      ge    = (cur >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= rad_q[k-1] << 2;
        rem_q[k]  <= ge ? (cur - trial) : cur;
        root_q[k] <= {root_q[k-1][LEN_W-2:0], ge};
        hd_q[k]   <= hd_q[k-1];
        bx_q[k]   <= bx_q[k-1];
      end
    end
  end

  assign valid_o = vld_q[LEN_W];
  assign len_o   = root_q[LEN_W];
  assign head_o  = hd_q[LEN_W];
  assign box_o   = bx_q[LEN_W];

endmodule

FILE: rtl/rbsi_norm.sv
// Scales the heading to unit length by restoring division, one quotient bit per stage.
module rbsi_norm (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic [rbsi_pkg::LEN_W-1:0]           len_i,
  input  rbsi_pkg::head_t                      head_i,
  input  rbsi_pkg::box_t                       box_i,
  output logic                                 valid_o,
  output logic [2:0][rbsi_pkg::UQ_W-1:0]       umag_o,
  output logic [2:0]                           uneg_o,
  output rbsi_pkg::box_t                       box_o
);

  localparam int LEN_W = rbsi_pkg::LEN_W;
  localparam int UQ_W  = rbsi_pkg::UQ_W;
  localparam int UN_W  = rbsi_pkg::UN_W;

  logic [2:0][LEN_W-1:0] rem_q [UQ_W+1];
  logic [2:0][UQ_W-1:0]  lo_q  [UQ_W+1];
  logic [2:0][UQ_W-1:0]  quo_q [UQ_W+1];
  logic [LEN_W-1:0]      len_q [UQ_W+1];
  logic [2:0]            neg_q [UQ_W+1];
  logic                  vld_q [UQ_W+1];
  rbsi_pkg::box_t        bx_q  [UQ_W+1];

  logic [2:0][UN_W-1:0]  num;

  // Round to nearest by adding half the divisor up front
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      num[a] = (UN_W'(head_i.mag[a]) << rbsi_pkg::FRAC_BITS) + UN_W'(len_i >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int a = 0; a < 3; a++) begin
        rem_q[0][a] <= LEN_W'(num[a][UN_W-1:UQ_W]);
        lo_q[0][a]  <= num[a][UQ_W-1:0];
      end
      quo_q[0] <= '0;
      len_q[0] <= len_i;
      neg_q[0] <= head_i.neg;
      bx_q[0]  <= box_i;
    end
  end

  for (genvar k = 1; k <= UQ_W; k++) begin : g_div
    logic [2:0][LEN_W:0] cur;
    logic [2:0]          ge;

    always_comb begin
      for (int a = 0; a < 3; a++) begin
        cur[a] = {rem_q[k-1][a], lo_q[k-1][a][UQ_W-1]};
        ge[a]  = (cur[a] >= {1'b0, len_q[k-1]});
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int a = 0; a < 3; a++) begin
          rem_q[k][a] <= ge[a] ? LEN_W'(cur[a] - {1'b0, len_q[k-1]}) : LEN_W'(cur[a]);
          lo_q[k][a]  <= lo_q[k-1][a] << 1;
          quo_q[k][a] <= {quo_q[k-1][a][UQ_W-2:0], ge[a]};
        end
        len_q[k] <= len_q[k-1];
        neg_q[k] <= neg_q[k-1];
        bx_q[k]  <= bx_q[k-1];
      end
    end
  end

  // A zero-length heading gives zero components
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      umag_o[a] = (len_q[UQ_W] == '0) ? '0 : quo_q[UQ_W][a];
    end
  end

  assign valid_o = vld_q[UQ_W];
  assign uneg_o  = neg_q[UQ_W];
  assign box_o   = bx_q[UQ_W];

endmodule

FILE: rtl/rbsi_slab.sv
// Divides the six slab offsets by the unit heading and saturates the ray parameters.
module rbsi_slab (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     en_i,
  input  logic                                     valid_i,
  input  logic [2:0][rbsi_pkg::UQ_W-1:0]           umag_i,
  input  logic [2:0]                               uneg_i,
  input  rbsi_pkg::box_t                           box_i,
  output logic                                     valid_o,
  output logic signed [5:0][rbsi_pkg::CW-1:0]      t_o,
  output rbsi_pkg::slab_flag_t                     flag_o
);

  localparam int CW   = rbsi_pkg::CW;
  localparam int DW   = rbsi_pkg::DW;
  localparam int UQ_W = rbsi_pkg::UQ_W;
  localparam int SN_W = rbsi_pkg::SN_W;
  localparam int TQ_W = rbsi_pkg::TQ_W;
  localparam int SH_W = rbsi_pkg::SH_W;

  logic [5:0][SH_W-1:0]  rem_q [TQ_W+1];
  logic [5:0][TQ_W-1:0]  lo_q  [TQ_W+1];
  logic [5:0][TQ_W-1:0]  quo_q [TQ_W+1];
  logic [5:0][UQ_W-1:0]  den_q [TQ_W+1];
  logic [5:0]            ovf_q [TQ_W+1];
  logic [5:0]            neg_q [TQ_W+1];
  rbsi_pkg::slab_flag_t  fl_q  [TQ_W+1];
  logic                  vld_q [TQ_W+1];

  logic [5:0][DW-1:0]    diff;
  logic [5:0][DW-1:0]    dmag;
  logic [5:0][SN_W-1:0]  num;
  logic [5:0][UQ_W-1:0]  den;
  logic [5:0]            uneg;
  rbsi_pkg::slab_flag_t  fl_d;

  logic                  out_vld_q;
  logic signed [5:0][CW-1:0] t_q;
  rbsi_pkg::slab_flag_t  out_fl_q;

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      diff[j] = (j < 3) ? box_i.dlo[j%3] : box_i.dhi[j%3];
      dmag[j] = diff[j][DW-1] ? (DW'(0) - diff[j]) : diff[j];
      num[j]  = SN_W'(dmag[j]) << rbsi_pkg::FRAC_BITS;
      den[j]  = umag_i[j%3];
      uneg[j] = uneg_i[j%3];
    end
    for (int a = 0; a < 3; a++) begin
      fl_d.uzero[a] = (umag_i[a] == '0);
      fl_d.zmiss[a] = box_i.dhi[a][DW-1] | (~box_i.dlo[a][DW-1] & (box_i.dlo[a] != '0));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0]  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q[0]  <= valid_i;
      out_vld_q <= vld_q[TQ_W];
    end
  end

  // Quotients of 2^TQ_W or more saturate, so flag them from the numerator head
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 6; j++) begin
        rem_q[0][j] <= num[j][SN_W-1:TQ_W];
        ovf_q[0][j] <= (num[j][SN_W-1:TQ_W] >= SH_W'(den[j]));
        lo_q[0][j]  <= num[j][TQ_W-1:0];
        den_q[0][j] <= den[j];
        neg_q[0][j] <= diff[j][DW-1] ^ uneg[j];
      end
      quo_q[0] <= '0;
      fl_q[0]  <= fl_d;
    end
  end

  for (genvar k = 1; k <= TQ_W; k++) begin : g_div
    logic [5:0][SH_W:0] cur;
    logic [5:0]         ge;

    always_comb begin
      for (int j = 0; j < 6; j++) begin
        cur[j] = {rem_q[k-1][j], lo_q[k-1][j][TQ_W-1]};
        ge[j]  = (cur[j] >= (SH_W+1)'(den_q[k-1][j]));
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int j = 0; j < 6; j++) begin
          rem_q[k][j] <= ge[j] ? SH_W'(cur[j] - (SH_W+1)'(den_q[k-1][j])) : SH_W'(cur[j]);
          lo_q[k][j]  <= lo_q[k-1][j] << 1;
          quo_q[k][j] <= {quo_q[k-1][j][TQ_W-2:0], ge[j]};
        end
        den_q[k] <= den_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
        neg_q[k] <= neg_q[k-1];
        fl_q[k]  <= fl_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 6; j++) begin
        if (ovf_q[TQ_W][j]) begin
          t_q[j] <= neg_q[TQ_W][j] ? rbsi_pkg::T_NEG_INF : rbsi_pkg::T_POS_INF;
        end else if (quo_q[TQ_W][j] == '0) begin
          t_q[j] <= '0;
        end else if (neg_q[TQ_W][j]) begin
          t_q[j] <= (quo_q[TQ_W][j] > TQ_W'(rbsi_pkg::T_NEG_INF)) ? rbsi_pkg::T_NEG_INF
                                                                 : CW'(-quo_q[TQ_W][j]);
        end else begin
          t_q[j] <= (quo_q[TQ_W][j] > TQ_W'(rbsi_pkg::T_POS_INF)) ? rbsi_pkg::T_POS_INF
                                                                 : CW'(quo_q[TQ_W][j]);
        end
      end
      out_fl_q <= fl_q[TQ_W];
    end
  end

  assign valid_o = out_vld_q;
  assign t_o     = t_q;
  assign flag_o  = out_fl_q;

endmodule

FILE: bench/tb_ray_box_slab_intersect.sv
// Testbench for the ray/box slab intersection pipeline: random and directed requests, scoreboard.
module tb_ray_box_slab_intersect;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = rbsi_pkg::FRAC_BITS;
  localparam longint NEG_INF = -64'sd2147483648;
  localparam longint POS_INF = 64'sd2147483647;

  typedef struct {
    logic [31:0] bmin [3];
    logic [31:0] bmax [3];
    logic [31:0] org [3];
    logic [31:0] head [3];
  } ray_req_t;

  typedef struct {
    logic        hit;
    logic [30:0] entry_len;
  } hit_res_t;

  function automatic longint unsigned absval(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint crossing_param(longint diff, longint u);
    longint unsigned q;
    bit neg;
    q = (absval(diff) << FB) / absval(u);
    neg = (diff < 0) != (u < 0);
    if (q == 0) return 0;
    if (neg) return q > 64'd2147483648 ? NEG_INF : -longint'(q);
    return q > 64'd2147483647 ? POS_INF : longint'(q);
  endfunction

  function automatic hit_res_t slab_hit(ray_req_t r);
    hit_res_t res;
    longint bl, bh, o, h, s, e, t, latest, earliest;
    longint unit [3];
    longint unsigned sum, len, q;
    res.hit = 0;
    res.entry_len = '0;
    latest = NEG_INF;
    earliest = POS_INF;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      h = longint'($signed(r.head[i]));
      sum += absval(h) * absval(h);
    end
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      h = longint'($signed(r.head[i]));
      if (len == 0) unit[i] = 0;
      else begin
        q = ((absval(h) << FB) + (len >> 1)) / len;
        unit[i] = h < 0 ? -longint'(q) : longint'(q);
      end
    end
    for (int i = 0; i < 3; i++) begin
      bl = longint'($signed(r.bmin[i]));
      bh = longint'($signed(r.bmax[i]));
      o = longint'($signed(r.org[i]));
      if (unit[i] != 0) begin
        s = crossing_param(bl - o, unit[i]);
        e = crossing_param(bh - o, unit[i]);
      end else if (o > bh || o < bl) begin
        return res;
      end else begin
        s = NEG_INF;
        e = POS_INF;
      end
      if (s > e) begin
        t = s; s = e; e = t;
      end
      if (e < 0) return res;
      if (s > latest) latest = s;
      if (e < earliest) earliest = e;
    end
    if (latest >= earliest) return res;
    res.hit = 1;
    res.entry_len = latest > 0 ? latest[30:0] : '0;
    return res;
  endfunction

  class hit_scoreboard;
    hit_res_t pending [$];
    int errors = 0;
    int checked = 0;
    int hits = 0;

    function void note_request(ray_req_t r);
      pending.push_back(slab_hit(r));
    endfunction

    function void check_result(logic [31:0] d);
      hit_res_t x;
      if (pending.size() == 0) begin
        $display("%t: unexpected result %h", $realtime, d);
        errors++;
        return;
      end
      x = pending.pop_front();
      checked++;
      if (x.hit) hits++;
      if (d[0] !== x.hit) begin
        $display("%t: hit expected %b actual %b", $realtime, x.hit, d[0]);
        errors++;
      end
      if (d[31:1] !== x.entry_len) begin
        $display("%t: hit_distance expected %h actual %h", $realtime, x.entry_len, d[31:1]);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic s_axis_tvalid_i = 0;
  logic s_axis_tready_o;
  logic [383:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 0;
  logic [31:0] m_axis_tdata_o;

  hit_scoreboard sb = new();
  ray_req_t sent [$];
  bit stim_done = 0;
  bit hold_off = 0;

  always #10 clk_i = ~clk_i;

  ray_box_slab_intersect DUT (.*);

  function automatic logic [383:0] pack_req(ray_req_t r);
    logic [383:0] d;
    for (int i = 0; i < 3; i++) begin
      d[32*i +: 32] = r.bmin[i];
      d[32*(3+i) +: 32] = r.bmax[i];
      d[32*(6+i) +: 32] = r.org[i];
      d[32*(9+i) +: 32] = r.head[i];
    end
    return d;
  endfunction

  function automatic int gap_len();
    int p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // coordinate with mixed scales: small values, full range, and corner values
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2, 3: return $urandom();
      4: return 32'($signed($urandom_range(0, 6)) - 3);
      default: return 32'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
    endcase
  endfunction

  function automatic ray_req_t rand_req();
    ray_req_t r;
    logic [31:0] a, b;
    for (int i = 0; i < 3; i++) begin
      a = rand_coord();
      b = rand_coord();
      // mostly well-formed boxes, sometimes inverted
      if ($urandom_range(0, 9) != 0 && $signed(a) > $signed(b)) begin
        r.bmin[i] = b; r.bmax[i] = a;
      end else begin
        r.bmin[i] = a; r.bmax[i] = b;
      end
      r.org[i] = rand_coord();
      r.head[i] = $urandom_range(0, 4) == 0 ? 32'h0 : rand_coord();
    end
    // aim the ray at the box now and then so hits are common
    if ($urandom_range(0, 2) == 0) begin
      for (int i = 0; i < 3; i++) begin
        a = 32'($signed(r.bmin[i]) / 2 + $signed(r.bmax[i]) / 2);
        r.head[i] = 32'(($signed(a) >>> 1) - ($signed(r.org[i]) >>> 1));
      end
    end
    return r;
  endfunction

  function automatic ray_req_t make_req(int bl, int bh, int o, int h);
    ray_req_t r;
    for (int i = 0; i < 3; i++) begin
      r.bmin[i] = bl; r.bmax[i] = bh; r.org[i] = o; r.head[i] = h;
    end
    return r;
  endfunction

  task automatic send_req(ray_req_t r);
    s_axis_tvalid_i <= 1;
    s_axis_tdata_i <= pack_req(r);
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_request(r);
  endtask

  task automatic send_all();
    int g;
    foreach (sent[k]) begin
      send_req(sent[k]);
      g = gap_len();
      if (g > 0) begin
        s_axis_tvalid_i <= 0;
        repeat (g) @(posedge clk_i);
      end
    end
    s_axis_tvalid_i <= 0;
  endtask

  // receiver: random stalls, plus one long hold-off while the sender keeps going
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
      if (hold_off) m_axis_tready_i <= 0;
      else if (g > 0) begin
        g--;
        m_axis_tready_i <= 0;
      end else begin
        m_axis_tready_i <= 1;
        if ($urandom_range(0, 3) == 0) g = gap_len();
      end
    end
  end

  initial begin
    @(posedge rst_ni);
    repeat (400) @(posedge clk_i);
    hold_off = 1;
    repeat (300) @(posedge clk_i);
    hold_off = 0;
  end

  initial begin
    ray_req_t r;
    int waited;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: inside start, hit ahead, behind, zero heading inside and outside the box, inverted box
    sent.push_back(make_req(-32'sh10000, 32'sh10000, 0, 32'sh10000));
    sent.push_back(make_req(32'sh50000, 32'sh60000, 0, 32'sh10000));
    sent.push_back(make_req(32'sh50000, 32'sh60000, 0, -32'sh10000));
    sent.push_back(make_req(-32'sh10000, 32'sh10000, 0, 0));
    sent.push_back(make_req(32'sh10000, 32'sh20000, 0, 0));
    sent.push_back(make_req(32'sh60000, 32'sh50000, 0, 32'sh10000));
    sent.push_back(make_req(32'h8000_0000, 32'h7fff_ffff, 0, 1));
    sent.push_back(make_req(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000));
    sent.push_back(make_req(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    sent.push_back(make_req(-1, -1, -1, -1));
    sent.push_back(make_req(32'hffff_ffff, 32'h0, 32'h8000_0000, 32'h0000_0001));
    r = make_req(32'sh10000, 32'sh20000, 0, 0);
    r.head[0] = 32'h7fff_ffff; r.head[1] = 1;       // tiny component rounds to zero
    sent.push_back(r);
    r.bmin[1] = -32'sh10000;
    sent.push_back(r);
    r = make_req(32'sh10000, 32'sh20000, 0, 0);
    r.head[2] = 32'h8000_0000; r.bmin[2] = 32'h8000_0000; r.bmax[2] = 32'h0;
    sent.push_back(r);
    r = make_req(32'sh7fff0000, 32'sh7fffffff, 32'h8000_0000, 32'sh1);
    sent.push_back(r);
    repeat (1700) sent.push_back(rand_req());
    send_all();
    waited = 0;
    while (sb.pending.size() != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (150) @(posedge clk_i);
    $display("Checked %0d results (%0d hits) from %0d requests, incl. edge and stall cases.",
             sb.checked, sb.hits, sent.size());
    if (sb.errors == 0 && sb.pending.size() == 0) $display("tb_ray_box_slab_intersect passed");
    else $display("tb_ray_box_slab_intersect failed");
    $finish;
  end

  initial begin
    #4ms;
    $display("tb_ray_box_slab_intersect failed");
    $finish;
  end
endmodule

FILE: ray_box_slab_intersect.f
rtl/rbsi_pkg.sv
rtl/rbsi_sqrt.sv
rtl/rbsi_norm.sv
rtl/rbsi_slab.sv
rtl/ray_box_slab_intersect.sv
bench/tb_ray_box_slab_intersect.sv
